>>> design/sws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

	localparam int TS_W           = 48;
	localparam int WIN_W          = 32;
	localparam int FRAC_W         = 16;
	localparam int SHARE_W        = FRAC_W + 1;
	localparam int CNT_OUT_W      = 9;
	localparam int FIFO_DEPTH_DEF = 256;

	localparam logic [WIN_W-1:0]   WIN_RESET = WIN_W'(10000);
	localparam logic [SHARE_W-1:0] SHARE_ONE = SHARE_W'(1) << FRAC_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REC_RD,
		ST_REC_WR,
		ST_QRY_RD,
		ST_QRY_CMP,
		ST_DIV,
		ST_OUT
	} sws_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic rec_write;
		logic drop;
		logic div_start;
		logic div_step;
		logic out_load;
	} sws_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mode;
		logic empty;
		logic expired;
		logic div_last;
		logic out_free;
	} sws_sts_t;

endpackage

`default_nettype wire

>>> design/sws_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sws_ctrl import sws_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire sws_sts_t sts,
	output sws_cmd_t      cmd
);

	sws_state_t state_q;
	sws_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.mode ? ST_QRY_RD : ST_REC_RD;
				end
			end
			ST_REC_RD:  state_d = ST_REC_WR;
			ST_REC_WR:  state_d = ST_IDLE;
			ST_QRY_RD:  state_d = ST_QRY_CMP;
			ST_QRY_CMP: begin
				priority if (sts.expired) begin
					state_d = ST_QRY_RD;
				end else if (sts.empty) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_REC_WR:  cmd.rec_write = 1'b1;
			ST_QRY_CMP: begin
				cmd.drop      = sts.expired;
				cmd.div_start = !sts.expired && !sts.empty;
			end
			ST_DIV:     cmd.div_step = 1'b1;
			ST_OUT:     cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> design/sws_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sws_dp import sws_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [WIN_W-1:0]     cfg_wr_data,
	input  wire logic                 mode,
	input  wire logic [TS_W-1:0]      timestamp_ms,
	input  wire logic                 success,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic [SHARE_W-1:0]        success_share,
	output logic [CNT_OUT_W-1:0]      total_count,
	output logic [CNT_OUT_W-1:0]      success_count,
	input  wire sws_cmd_t             cmd,
	output sws_sts_t                  sts
);

	localparam int AW  = $clog2(FIFO_DEPTH);
	localparam int CW  = $clog2(FIFO_DEPTH + 1);
	localparam int DW  = CW + FRAC_W;
	localparam int NW  = $clog2(DW);
	localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
	localparam logic [AW:0]   DEPTH_A = (AW + 1)'(FIFO_DEPTH);

	// Entry store: outcome in the top bit, timestamp below
	logic [TS_W:0] mem [FIFO_DEPTH];
	logic [TS_W:0] rd_q;

	logic [WIN_W-1:0] window_q;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    good_q;

	logic [TS_W-1:0]  ts_q;
	logic             ok_q;
	logic [TS_W-1:0]  limit_q;

	logic [CW-1:0]    rem_q;
	logic [DW-1:0]    dvd_q;
	logic [DW-1:0]    quo_q;
	logic [NW-1:0]    dcnt_q;

	logic             out_valid_q;
	logic [SHARE_W-1:0]   share_q;
	logic [CNT_OUT_W-1:0] total_q;
	logic [CNT_OUT_W-1:0] good_out_q;

	logic            full;
	logic            empty;
	logic            head_good;
	logic [AW-1:0]   head_inc;
	logic [AW:0]     slot_sum;
	logic [AW-1:0]   slot;
	logic [CW-1:0]   good_dropped;
	logic [CW:0]     trial;
	logic            trial_ge;
	logic [TS_W-1:0] win_ext;

	assign full      = (count_q == DEPTH_C);
	assign empty     = (count_q == '0);
	assign head_good = rd_q[TS_W] && (good_q != '0);
	assign head_inc  = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign good_dropped = head_good ? good_q - CW'(1) : good_q;

	// Tail slot; a full store writes over the head it drops
	assign slot_sum = (AW + 1)'(head_q) + (AW + 1)'(count_q);
	always_comb begin
		if (full) begin
			slot = head_q;
		end else if (slot_sum >= DEPTH_A) begin
			slot = AW'(slot_sum - DEPTH_A);
		end else begin
			slot = AW'(slot_sum);
		end
	end

	assign win_ext  = TS_W'(window_q);
	assign trial    = {rem_q, dvd_q[DW-1]};
	assign trial_ge = (trial >= {1'b0, count_q});

	always_ff @(posedge clk) begin
		if (cmd.rec_write) begin
			mem[slot] <= {ok_q, ts_q};
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
			head_q   <= '0;
			count_q  <= '0;
			good_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			if (cmd.rec_write) begin
				if (full) begin
					head_q <= head_inc;
					good_q <= good_dropped + CW'(ok_q);
				end else begin
					count_q <= count_q + CW'(1);
					good_q  <= good_q + CW'(ok_q);
				end
			end else if (cmd.drop) begin
				head_q  <= head_inc;
				count_q <= count_q - CW'(1);
				good_q  <= good_dropped;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ts_q    <= timestamp_ms;
			ok_q    <= success;
			// Clamp at zero when the time is still inside the first window
			limit_q <= (timestamp_ms >= win_ext) ? timestamp_ms - win_ext : '0;
		end
		if (cmd.div_start) begin
			rem_q  <= '0;
			dvd_q  <= {good_q, FRAC_W'(0)};
			quo_q  <= '0;
			dcnt_q <= NW'(DW - 1);
		end else if (cmd.div_step) begin
			rem_q  <= trial_ge ? CW'(trial - {1'b0, count_q}) : CW'(trial);
			dvd_q  <= {dvd_q[DW-2:0], 1'b0};
			quo_q  <= {quo_q[DW-2:0], trial_ge};
			dcnt_q <= dcnt_q - NW'(1);
		end
		if (cmd.out_load) begin
			share_q    <= empty ? SHARE_ONE : quo_q[SHARE_W-1:0];
			total_q    <= CNT_OUT_W'(count_q);
			good_out_q <= CNT_OUT_W'(good_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign success_share = share_q;
	assign total_count   = total_q;
	assign success_count = good_out_q;

	assign sts.mode     = mode;
	assign sts.empty    = empty;
	assign sts.expired  = !empty && (rd_q[TS_W-1:0] < limit_q);
	assign sts.div_last = (dcnt_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	a_good_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		good_q <= count_q)
		else $error("successful entries exceed held entries");

	a_count_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond store depth");

	a_drop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |=> count_q == $past(count_q) - CW'(1))
		else $error("expiry did not retire exactly one entry");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready)
		else $error("result loaded over a beat not yet taken");

endmodule

`default_nettype wire

>>> design/sliding_window_success_rate_top.sv
// Sliding time window success ratio. Record beats (mode 0) append a call
// outcome with its millisecond timestamp to a FIFO of FIFO_DEPTH entries and
// give no result; when the FIFO is full the oldest entry is dropped first.
// Query beats (mode 1) first retire head entries whose time lies below the
// query time minus window_ms (nothing retires while the query time is still
// below the window), then return one result: retained entries, retained
// successes and floor(successes * 65536 / entries), or 65536 when the FIFO
// is empty. Expiry inspects only the head, so a late out-of-order entry
// stops it. A record passes accept, head read and write states; a query
// passes accept, a head read and a compare state per retired entry (the
// entry memory read is registered), a bit-serial restoring division of
// clog2(FIFO_DEPTH+1) + 16 steps and an output state. An empty FIFO skips
// the division. The result sits in an output register, so new beats are
// taken while it waits. The user must write window_ms through cfg_wr_en/
// cfg_wr_data only while the block is idle; the block does not enforce it.
// The entry memory needs no clearing after reset: only held entries are read.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_success_rate_top import sws_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [WIN_W-1:0]     cfg_wr_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 mode,
	input  wire logic [TS_W-1:0]      timestamp_ms,
	input  wire logic                 success,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [SHARE_W-1:0]        success_share,
	output logic [CNT_OUT_W-1:0]      total_count,
	output logic [CNT_OUT_W-1:0]      success_count
);

	// Command and status between sequencer and datapath
	sws_cmd_t cmd;
	sws_sts_t sts;

	// Sequencer: accept, walk expired head entries, divide, hand over result
	sws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: entry memory, pointers and counts, divider, output register
	sws_dp #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.mode          (mode),
		.timestamp_ms  (timestamp_ms),
		.success       (success),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.success_share (success_share),
		.total_count   (total_count),
		.success_count (success_count),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

`default_nettype wire
